FILE: rtl/second_order_tracking_differentiator_core_defines.svh
// Assertion macros used by the checker file sotd_chk.sv.
`ifndef SECOND_ORDER_TRACKING_DIFFERENTIATOR_CORE_DEFINES_SVH
`define SECOND_ORDER_TRACKING_DIFFERENTIATOR_CORE_DEFINES_SVH

// cons must hold in the same cycle as ante
`define SOTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define SOTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sotd_pkg.sv
`default_nettype none

package sotd_pkg;

    localparam int VALUE_W       = 32;   // Q15.16 values
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 24;   // unsigned Q8.16 gains
    localparam int COEF_FRAC     = 16;
    localparam int STEP_W        = 16;   // unsigned Q0.16 step time
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_ADDR_W    = 2;
    localparam int MUL_DIGIT     = 4;    // gain bits consumed per multiplier cycle

    // pi * 2^30, rounded
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [CFG_ADDR_W-1:0] CFG_K_POS     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_K_DAMP    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_TIME = 2'd2;

    typedef enum logic [2:0] {
        KIND_UPDATE = 3'd0,
        KIND_ANGLE  = 3'd1,
        KIND_WRAP   = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_PRESET = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]                kind;
        logic signed [VALUE_W-1:0] target_value;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] smoothed_position;
        logic signed [VALUE_W-1:0] rate_estimate;
    } t_out_req;

endpackage

`default_nettype wire

FILE: rtl/second_order_tracking_differentiator_core.sv
// Second-order tracking differentiator with optional angle unwrap.
// Input channel (i_in_valid / o_in_ready / i_in) carries one request: a kind and a
// Q15.16 target. Kinds: update, angle update (target unwrapped by the shortest step
// mod 2*pi, position wrapped to [-pi,pi)), wrap-only update, clear, preset.
// Result channel (o_out_valid / i_out_ready / o_out) carries position and velocity;
// only the three update kinds give a result. Gains sit behind a plain write port
// (i_cfg_we / i_cfg_addr / i_cfg_wdata), written while the block is idle.
// Timing: clear, preset and unused kinds finish in the accept cycle, ready stays high.
// An update runs three digit-serial multiplies (4 gain bits per cycle) plus glue.
// Wrap-only adds one radix-4 remainder against 2*pi for the output wrap, angle
// update two (the other unwraps); each has D = ceil((max(32, FRAC_BITS+3)+1)/2)
// steps (D = 17 by default). One request at a time; ready returns in the same
// cycle the result is registered.
// A stalled receiver holds the result register; a new request is still taken and
// only waits at its own end until the register frees. Reset (synchronous,
// active low) zeroes gains, target, position, velocity and empties the result.
`default_nettype none

module second_order_tracking_differentiator_core #(
    parameter int FRAC_BITS = sotd_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sotd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sotd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sotd_pkg::t_in_req               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sotd_pkg::t_out_req              o_out
);
    import sotd_pkg::*;

    localparam int VW        = VALUE_W;
    localparam int REM_W     = FRAC_BITS + 3;            // holds anything below 2*pi
    localparam int DIV_W0    = ((VW > REM_W) ? VW : REM_W) + 1;
    localparam int DIV_W     = DIV_W0 + (DIV_W0 % 2);    // even: two bits per step
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int WW        = DIV_W + 3;                // wide signed work width
    localparam int MUL_STEPS = COEF_W / MUL_DIGIT;
    localparam int MCNT_W    = $clog2(MUL_STEPS);
    localparam int PROD_W    = VW + COEF_W;
    localparam int Q_W       = PROD_W - COEF_FRAC;

    localparam logic [63:0] PI_FULL =
        (PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam logic [REM_W-1:0]     PI_R      = PI_FULL[REM_W-1:0];
    localparam logic [REM_W-1:0]     TWO_PI    = REM_W'(PI_FULL << 1);
    localparam logic signed [WW-1:0] PI_WW     = $signed(WW'(PI_FULL));
    localparam logic signed [WW-1:0] TWO_PI_WW = $signed(WW'(PI_FULL << 1));
    localparam logic signed [WW-1:0] WMAX =
        $signed({{(WW-VW+1){1'b0}}, {(VW-1){1'b1}}});
    localparam logic signed [WW-1:0] WMIN =
        $signed({{(WW-VW+1){1'b1}}, {(VW-1){1'b0}}});

    // one-hot sequencer
    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_DIV     = 14'b00000000000010,  // radix-4 remainder mod 2*pi
        S_UNW_D   = 14'b00000000000100,  // shortest unwrap step
        S_UNW_ADD = 14'b00000000001000,  // unwrapped target
        S_ERR     = 14'b00000000010000,  // start k_pos * error
        S_MUL     = 14'b00000000100000,  // multiplier digits
        S_COL     = 14'b00000001000000,  // collect product
        S_ACC     = 14'b00000010000000,  // acceleration term
        S_VEL     = 14'b00000100000000,  // velocity update
        S_STEPLD  = 14'b00001000000000,  // start velocity * step_time
        S_POS     = 14'b00010000000000,  // position update
        S_WLOAD   = 14'b00100000000000,  // start output wrap
        S_WFIX    = 14'b01000000000000,  // wrapped position
        S_OUT     = 14'b10000000000000   // hand result to output register
    } t_state;

    typedef enum logic [1:0] {
        MS_ERR  = 2'd0,
        MS_DAMP = 2'd1,
        MS_STEP = 2'd2
    } t_mul_sel;

    function automatic logic signed [VW-1:0] sat_w(input logic signed [WW-1:0] x);
        if (x > WMAX) return WMAX[VW-1:0];
        if (x < WMIN) return WMIN[VW-1:0];
        return x[VW-1:0];
    endfunction

    // one restoring step of the remainder against 2*pi
    function automatic logic [REM_W-1:0] div_bit(input logic [REM_W-1:0] r,
                                                 input logic b);
        logic [REM_W:0] t;
        t = {r, b};
        if (t >= {1'b0, TWO_PI}) t = t - {1'b0, TWO_PI};
        return t[REM_W-1:0];
    endfunction

    // architectural state and gains
    t_state                  r_state, n_state;
    logic [COEF_W-1:0]       r_k_pos, n_k_pos;
    logic [COEF_W-1:0]       r_k_damp, n_k_damp;
    logic [STEP_W-1:0]       r_step_time, n_step_time;
    logic signed [VW-1:0]    r_held, n_held;
    logic signed [VW-1:0]    r_pos, n_pos;
    logic signed [VW-1:0]    r_vel, n_vel;
    logic                    r_out_valid, n_out_valid;
    t_out_req                r_out, n_out;

    // working registers
    logic [2:0]              r_kind, n_kind;
    logic signed [VW-1:0]    r_target, n_target;
    logic [DIV_W-1:0]        r_div_sh, n_div_sh;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic                    r_div_neg, n_div_neg;
    logic                    r_div_wrap, n_div_wrap;
    logic [DCNT_W-1:0]       r_div_cnt, n_div_cnt;
    logic [VW-1:0]           r_mul_m, n_mul_m;
    logic [COEF_W-1:0]       r_mul_c, n_mul_c;
    logic [VW-1:0]           r_mul_hi, n_mul_hi;
    logic [COEF_W-1:0]       r_mul_lo, n_mul_lo;
    logic                    r_mul_neg, n_mul_neg;
    logic [MCNT_W-1:0]       r_mul_cnt, n_mul_cnt;
    t_mul_sel                r_mul_sel, n_mul_sel;
    logic signed [VW-1:0]    r_prod_a, n_prod_a;
    logic signed [VW-1:0]    r_prod_b, n_prod_b;
    logic signed [VW:0]      r_dlt, n_dlt;
    logic signed [VW-1:0]    r_res_pos, n_res_pos;

    // datapath
    logic signed [WW-1:0]    in_diff;
    logic [WW-1:0]           in_diff_abs;
    logic signed [WW-1:0]    err_diff;
    logic [WW-1:0]           err_abs;
    logic signed [WW-1:0]    wrap_sum;
    logic [WW-1:0]           wrap_abs;
    logic [VW-1:0]           vel_abs;
    logic [REM_W-1:0]        div_rem_next;
    logic signed [WW-1:0]    rem_w;
    logic signed [WW-1:0]    unw_dm;
    logic signed [WW-1:0]    unw_d;
    logic [REM_W-1:0]        wrap_r;
    logic signed [WW-1:0]    wrap_res;
    logic [VW+MUL_DIGIT-1:0] mul_sum;
    logic [PROD_W-1:0]       mul_prod;
    logic [Q_W-1:0]          mul_q;
    logic [VW-1:0]           mul_mag;
    logic signed [VW-1:0]    mul_val;

    assign in_diff     = WW'(i_in.target_value) - WW'(r_held);
    assign in_diff_abs = in_diff[WW-1] ? -in_diff : in_diff;
    assign err_diff    = WW'(r_target) - WW'(r_pos);
    assign err_abs     = err_diff[WW-1] ? -err_diff : err_diff;
    assign wrap_sum    = WW'(r_pos) + PI_WW;
    assign wrap_abs    = wrap_sum[WW-1] ? -wrap_sum : wrap_sum;
    assign vel_abs     = r_vel[VW-1] ? VW'(-r_vel) : r_vel;

    assign div_rem_next = div_bit(div_bit(r_rem, r_div_sh[DIV_W-1]), r_div_sh[DIV_W-2]);

    // remainder above pi: step the other way round the circle
    assign rem_w  = $signed(WW'(r_rem));
    assign unw_dm = (r_rem > PI_R) ? rem_w - TWO_PI_WW : rem_w;
    assign unw_d  = r_div_neg ? -unw_dm : unw_dm;

    // floor modulo from the magnitude remainder, then shift back by pi
    assign wrap_r   = (r_div_neg && (r_rem != '0)) ? TWO_PI - r_rem : r_rem;
    assign wrap_res = $signed(WW'(wrap_r)) - PI_WW;

    // digit-serial multiply, gain LSB digit first
    assign mul_sum = {{MUL_DIGIT{1'b0}}, r_mul_hi}
                   + {{MUL_DIGIT{1'b0}}, r_mul_m} * {{VW{1'b0}}, r_mul_c[MUL_DIGIT-1:0]};
    assign mul_prod = {r_mul_hi, r_mul_lo};
    assign mul_q    = mul_prod[PROD_W-1:COEF_FRAC];
    assign mul_mag  = {1'b0, mul_q[VW-2:0]};

    // truncate toward zero, then saturate on the sign-magnitude product
    always_comb begin
        if (|mul_q[Q_W-1:VW-1]) begin
            mul_val = r_mul_neg ? WMIN[VW-1:0] : WMAX[VW-1:0];
        end else begin
            mul_val = r_mul_neg ? -$signed(mul_mag) : $signed(mul_mag);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_k_pos     = r_k_pos;
        n_k_damp    = r_k_damp;
        n_step_time = r_step_time;
        n_held      = r_held;
        n_pos       = r_pos;
        n_vel       = r_vel;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_kind      = r_kind;
        n_target    = r_target;
        n_div_sh    = r_div_sh;
        n_rem       = r_rem;
        n_div_neg   = r_div_neg;
        n_div_wrap  = r_div_wrap;
        n_div_cnt   = r_div_cnt;
        n_mul_m     = r_mul_m;
        n_mul_c     = r_mul_c;
        n_mul_hi    = r_mul_hi;
        n_mul_lo    = r_mul_lo;
        n_mul_neg   = r_mul_neg;
        n_mul_cnt   = r_mul_cnt;
        n_mul_sel   = r_mul_sel;
        n_prod_a    = r_prod_a;
        n_prod_b    = r_prod_b;
        n_dlt       = r_dlt;
        n_res_pos   = r_res_pos;

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_K_POS:     n_k_pos     = i_cfg_wdata;
                CFG_K_DAMP:    n_k_damp    = i_cfg_wdata;
                CFG_STEP_TIME: n_step_time = i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in.kind)
                        KIND_UPDATE, KIND_WRAP: begin
                            n_kind   = i_in.kind;
                            n_target = i_in.target_value;
                            n_state  = S_ERR;
                        end
                        KIND_ANGLE: begin
                            n_kind     = i_in.kind;
                            n_target   = i_in.target_value;
                            n_div_neg  = in_diff[WW-1];
                            n_div_sh   = in_diff_abs[DIV_W-1:0];
                            n_rem      = '0;
                            n_div_cnt  = DCNT_W'(DIV_STEPS - 1);
                            n_div_wrap = 1'b0;
                            n_state    = S_DIV;
                        end
                        KIND_CLEAR: begin
                            n_held = '0;
                            n_pos  = '0;
                            n_vel  = '0;
                        end
                        KIND_PRESET: begin
                            n_held = i_in.target_value;
                            n_pos  = i_in.target_value;
                            n_vel  = '0;
                        end
                        default: ;  // unused kinds are dropped
                    endcase
                end
            end
            S_DIV: begin
                n_rem     = div_rem_next;
                n_div_sh  = r_div_sh << 2;
                n_div_cnt = r_div_cnt - 1'b1;
                if (r_div_cnt == '0) n_state = r_div_wrap ? S_WFIX : S_UNW_D;
            end
            S_UNW_D: begin
                n_dlt   = unw_d[VW:0];
                n_state = S_UNW_ADD;
            end
            S_UNW_ADD: begin
                n_target = sat_w(WW'(r_held) + WW'(r_dlt));
                n_state  = S_ERR;
            end
            S_ERR: begin
                n_held    = r_target;
                n_mul_m   = err_abs[VW-1:0];
                n_mul_neg = err_diff[WW-1];
                n_mul_c   = r_k_pos;
                n_mul_hi  = '0;
                n_mul_cnt = MCNT_W'(MUL_STEPS - 1);
                n_mul_sel = MS_ERR;
                n_state   = S_MUL;
            end
            S_MUL: begin
                n_mul_hi  = mul_sum[VW+MUL_DIGIT-1:MUL_DIGIT];
                n_mul_lo  = {mul_sum[MUL_DIGIT-1:0], r_mul_lo[COEF_W-1:MUL_DIGIT]};
                n_mul_c   = r_mul_c >> MUL_DIGIT;
                n_mul_cnt = r_mul_cnt - 1'b1;
                if (r_mul_cnt == '0) n_state = S_COL;
            end
            S_COL: begin
                unique case (r_mul_sel)
                    MS_ERR: begin
                        n_prod_a  = mul_val;
                        n_mul_m   = vel_abs;
                        n_mul_neg = r_vel[VW-1];
                        n_mul_c   = r_k_damp;
                        n_mul_hi  = '0;
                        n_mul_cnt = MCNT_W'(MUL_STEPS - 1);
                        n_mul_sel = MS_DAMP;
                        n_state   = S_MUL;
                    end
                    MS_DAMP: begin
                        n_prod_b = mul_val;
                        n_state  = S_ACC;
                    end
                    MS_STEP: begin
                        n_prod_b = mul_val;
                        n_state  = S_POS;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ACC: begin
                n_prod_a = sat_w(WW'(r_prod_a) - WW'(r_prod_b));
                n_state  = S_VEL;
            end
            S_VEL: begin
                n_vel   = sat_w(WW'(r_vel) + WW'(r_prod_a));
                n_state = S_STEPLD;
            end
            S_STEPLD: begin
                n_mul_m   = vel_abs;
                n_mul_neg = r_vel[VW-1];
                n_mul_c   = {{(COEF_W-STEP_W){1'b0}}, r_step_time};
                n_mul_hi  = '0;
                n_mul_cnt = MCNT_W'(MUL_STEPS - 1);
                n_mul_sel = MS_STEP;
                n_state   = S_MUL;
            end
            S_POS: begin
                n_pos     = sat_w(WW'(r_pos) + WW'(r_prod_b));
                n_res_pos = n_pos;
                n_state   = (r_kind == KIND_UPDATE) ? S_OUT : S_WLOAD;
            end
            S_WLOAD: begin
                n_div_neg  = wrap_sum[WW-1];
                n_div_sh   = wrap_abs[DIV_W-1:0];
                n_rem      = '0;
                n_div_cnt  = DCNT_W'(DIV_STEPS - 1);
                n_div_wrap = 1'b1;
                n_state    = S_DIV;
            end
            S_WFIX: begin
                n_res_pos = sat_w(wrap_res);
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out.smoothed_position = r_res_pos;
                    n_out.rate_estimate     = r_vel;
                    n_state                 = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k_pos     <= '0;
            r_k_damp    <= '0;
            r_step_time <= '0;
            r_held      <= '0;
            r_pos       <= '0;
            r_vel       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_k_pos     <= n_k_pos;
            r_k_damp    <= n_k_damp;
            r_step_time <= n_step_time;
            r_held      <= n_held;
            r_pos       <= n_pos;
            r_vel       <= n_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_kind     <= n_kind;
        r_target   <= n_target;
        r_div_sh   <= n_div_sh;
        r_rem      <= n_rem;
        r_div_neg  <= n_div_neg;
        r_div_wrap <= n_div_wrap;
        r_div_cnt  <= n_div_cnt;
        r_mul_m    <= n_mul_m;
        r_mul_c    <= n_mul_c;
        r_mul_hi   <= n_mul_hi;
        r_mul_lo   <= n_mul_lo;
        r_mul_neg  <= n_mul_neg;
        r_mul_cnt  <= n_mul_cnt;
        r_mul_sel  <= n_mul_sel;
        r_prod_a   <= n_prod_a;
        r_prod_b   <= n_prod_b;
        r_dlt      <= n_dlt;
        r_res_pos  <= n_res_pos;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: rtl/sotd_chk.sv
`default_nettype none
`include "second_order_tracking_differentiator_core_defines.svh"

module sotd_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input sotd_pkg::t_in_req       i_in,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input sotd_pkg::t_out_req      o_out
);
    import sotd_pkg::*;

    logic in_fire;
    logic in_update;

    assign in_fire   = i_in_valid && o_in_ready;
    assign in_update = (i_in.kind == KIND_UPDATE) || (i_in.kind == KIND_ANGLE) ||
                       (i_in.kind == KIND_WRAP);

    `SOTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result dropped or changed while stalled")

    // an update request keeps the block busy
    `SOTD_ASSERT_NEXT(a_busy_after_update, i_clk, i_rst_n, in_fire && in_update, !o_in_ready, "ready after update request")

    // clear, preset and unused kinds finish in the accept cycle
    `SOTD_ASSERT_NEXT(a_ready_after_other, i_clk, i_rst_n, in_fire && !in_update, o_in_ready, "busy after non-update request")

    // a new result appears only as the block goes from busy back to idle
    `SOTD_ASSERT_NOW(a_result_at_done, i_clk, i_rst_n, $rose(o_out_valid), o_in_ready && !$past(o_in_ready), "result without finished update")

endmodule

bind second_order_tracking_differentiator_core sotd_chk u_sotd_chk (.*);

`default_nettype wire

FILE: bench/second_order_tracking_differentiator_core_tb.sv
// Bench for the second-order tracking differentiator.
//
// A driver takes requests from a queue that the stimulus process fills, drives
// them on the input channel and runs the tracker predictor on every accepted
// request. Updates push their expected position/rate pair; clear, preset and
// spare kinds push nothing. A monitor takes results with a random ready and
// checks them field by field against the oldest expected pair.
//
// Gains only change when the block is idle: queue drained, no request pending,
// no result outstanding, then a pause longer than the slowest request.
module second_order_tracking_differentiator_core_tb;
    import sotd_pkg::*;

    localparam int     CLK_HALF      = 4;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     SETTLE_CYCLES = 80;       // longer than the slowest request, an angle update
    localparam int     PHASE_ITEMS   = 250;

    // kinds the block must ignore
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam longint VAL_MAX   = 64'sd2147483647;
    localparam longint VAL_MIN   = -64'sd2147483648;
    // pi in Q15.16, rounded to nearest from the Q30 constant
    localparam longint PI_FX     = (longint'(PI_Q30) + (64'sd1 <<< (29 - FRAC_BITS_DEF)))
                                   >>> (30 - FRAC_BITS_DEF);
    localparam longint TWO_PI_FX = 2 * PI_FX;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_req               i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_req              o_out;

    second_order_tracking_differentiator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_in_req  queued_requests[$];   // requests not yet driven
    t_out_req tracked_outputs[$];   // expected results, oldest first
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 22;
    int       recv_idle_pct  = 70;
    longint   target_walk    = 0;

    // predictor copy of the gains and tracker state (all zero after reset)
    logic [COEF_W-1:0] kpos_q  = '0;
    logic [COEF_W-1:0] kdamp_q = '0;
    logic [STEP_W-1:0] step_q  = '0;
    longint            held_tgt = 0;
    longint            trk_pos  = 0;
    longint            trk_vel  = 0;

    // ------------------------------------------------------------------
    // Tracker predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_val(longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    // value times unsigned Q.16 gain, truncated toward zero, saturated
    function automatic longint gain_mul(longint a, logic [COEF_W-1:0] c);
        logic [63:0] mag;
        logic [95:0] prod;
        longint      q;
        mag  = (a < 0) ? 64'(-a) : 64'(a);
        prod = ({32'd0, mag} * {72'd0, c}) >> COEF_FRAC;
        if (prod > 96'h1_0000_0000) q = 64'sh1_0000_0000;
        else q = longint'(prod[63:0]);
        return clamp_val((a < 0) ? -q : q);
    endfunction

    // fold into [-pi, pi)
    function automatic longint wrap_pi(longint x);
        longint r;
        r = (x + PI_FX) % TWO_PI_FX;
        if (r < 0) r += TWO_PI_FX;
        return clamp_val(r - PI_FX);
    endfunction

    task automatic advance_tracker(input t_in_req req, output bit has_res,
                                   output t_out_req res);
        longint tgt;
        longint d;
        longint acc;
        longint pos;
        has_res = 1'b0;
        res     = '0;
        tgt     = req.target_value;
        case (req.kind)
            KIND_CLEAR: begin
                held_tgt = 0;
                trk_pos  = 0;
                trk_vel  = 0;
            end
            KIND_PRESET: begin
                held_tgt = tgt;
                trk_pos  = tgt;
                trk_vel  = 0;
            end
            KIND_UPDATE, KIND_ANGLE, KIND_WRAP: begin
                if (req.kind == KIND_ANGLE) begin
                    // shortest step from the held target, remainder keeps its sign
                    d = (tgt - held_tgt) % TWO_PI_FX;
                    if (d > PI_FX) d -= TWO_PI_FX;
                    else if (d < -PI_FX) d += TWO_PI_FX;
                    tgt = clamp_val(held_tgt + d);
                end
                // semi-implicit Euler: velocity first, then position
                acc      = gain_mul(tgt - trk_pos, kpos_q) - gain_mul(trk_vel, kdamp_q);
                held_tgt = tgt;
                trk_vel  = clamp_val(trk_vel + clamp_val(acc));
                trk_pos  = clamp_val(trk_pos + gain_mul(trk_vel, {8'd0, step_q}));
                pos      = (req.kind == KIND_UPDATE) ? trk_pos : wrap_pi(trk_pos);
                res.smoothed_position = pos[VALUE_W-1:0];
                res.rate_estimate     = trk_vel[VALUE_W-1:0];
                has_res  = 1'b1;
            end
            default: ;  // spare kinds: no state change
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver: predicts at the accept edge, then loads the next one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : request_drive
        bit       got_result;
        t_out_req predicted;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_tracker(i_in, got_result, predicted);
                if (got_result) tracked_outputs.push_back(predicted);
            end
            // valid holds until accepted; only reload when the slot frees
            if (!i_in_valid || o_in_ready) begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in       <= queued_requests.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_req want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (tracked_outputs.size() == 0) begin
                    $error("unexpected result: smoothed_position %0d rate_estimate %0d",
                           o_out.smoothed_position, o_out.rate_estimate);
                    mismatch_count++;
                end else begin
                    want = tracked_outputs.pop_front();
                    if (o_out.smoothed_position !== want.smoothed_position) begin
                        $error("smoothed_position: expected %0d, got %0d",
                               want.smoothed_position, o_out.smoothed_position);
                        mismatch_count++;
                    end
                    if (o_out.rate_estimate !== want.rate_estimate) begin
                        $error("rate_estimate: expected %0d, got %0d",
                               want.rate_estimate, o_out.rate_estimate);
                        mismatch_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [2:0] k, input logic signed [VALUE_W-1:0] v);
        t_in_req r;
        r.kind         = k;
        r.target_value = v;
        queued_requests.push_back(r);
    endtask

    // wait for every request and result, then let the block settle
    task automatic drain_block();
        @(negedge i_clk);
        while (queued_requests.size() != 0 || i_in_valid || tracked_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // step time register is 16 bits; junk in the upper data bits must be dropped
    task automatic set_gains(input logic [COEF_W-1:0] kp, input logic [COEF_W-1:0] kd,
                             input logic [STEP_W-1:0] st);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_K_POS;
        i_cfg_wdata <= kp;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_K_DAMP;
        i_cfg_wdata <= kd;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_STEP_TIME;
        i_cfg_wdata <= {8'($urandom), st};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        kpos_q  = kp;
        kdamp_q = kd;
        step_q  = st;
    endtask

    function automatic logic signed [VALUE_W-1:0] extreme_value();
        case ($urandom_range(5))
            0: return VALUE_W'(VAL_MAX);
            1: return VALUE_W'(VAL_MIN);
            2: return '0;
            3: return VALUE_W'(PI_FX);
            4: return VALUE_W'(-PI_FX);
            default: return '1;
        endcase
    endfunction

    // mostly a random walk with steps up to pi so angles cross the seam
    function automatic logic signed [VALUE_W-1:0] next_target();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return $urandom;
        if (pick == 1) return extreme_value();
        target_walk += longint'($urandom_range(32'(TWO_PI_FX))) - PI_FX;
        if (target_walk > 4 * PI_FX || target_walk < -4 * PI_FX)
            target_walk = -target_walk / 2;
        return VALUE_W'(target_walk);
    endfunction

    // bursts of one update kind, usually opened by preset or clear,
    // with a little noise of any kind and any value
    task automatic fill_random(input int count);
        logic [2:0] burst_kind;
        int         n;
        int         open_pick;
        n = 0;
        while (n < count) begin
            case ($urandom_range(2))
                0: burst_kind = KIND_UPDATE;
                1: burst_kind = KIND_ANGLE;
                default: burst_kind = KIND_WRAP;
            endcase
            open_pick = $urandom_range(9);
            if (open_pick < 5) begin
                queue_req(KIND_PRESET, next_target());
            end else if (open_pick < 7) begin
                target_walk = 0;
                queue_req(KIND_CLEAR, $urandom);
            end
            repeat ($urandom_range(30, 4)) begin
                if ($urandom_range(19) == 0) begin
                    if ($urandom_range(1) == 0)
                        queue_req(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)), $urandom);
                    else
                        queue_req(3'($urandom_range(KIND_PRESET, KIND_UPDATE)), $urandom);
                end else begin
                    queue_req(burst_kind, next_target());
                end
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int ph;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset gains are zero: velocity and position must not move
        @(negedge i_clk);
        queue_req(KIND_PRESET, 32'sh0030_3900);
        queue_req(KIND_UPDATE, VALUE_W'(VAL_MAX));
        queue_req(KIND_ANGLE, VALUE_W'(VAL_MIN));
        queue_req(KIND_WRAP, '0);
        drain_block();

        // directed corners under typical gains
        set_gains(24'd2621, 24'd19661, 16'd655);
        @(negedge i_clk);
        queue_req(KIND_PRESET, '0);
        queue_req(KIND_UPDATE, VALUE_W'(VAL_MAX));
        queue_req(KIND_UPDATE, VALUE_W'(VAL_MAX));
        queue_req(KIND_UPDATE, VALUE_W'(VAL_MIN));
        queue_req(KIND_PRESET, VALUE_W'(VAL_MAX));
        queue_req(KIND_UPDATE, VALUE_W'(VAL_MIN));        // error beyond value range
        queue_req(KIND_PRESET, VALUE_W'(VAL_MIN));
        queue_req(KIND_UPDATE, VALUE_W'(VAL_MAX));
        queue_req(KIND_CLEAR, VALUE_W'(VAL_MAX));
        queue_req(KIND_ANGLE, VALUE_W'(PI_FX));           // step of exactly pi
        queue_req(KIND_ANGLE, VALUE_W'(-PI_FX));
        queue_req(KIND_ANGLE, VALUE_W'(VAL_MAX));         // unwrap from far away
        queue_req(KIND_ANGLE, VALUE_W'(VAL_MIN));
        queue_req(KIND_WRAP, VALUE_W'(VAL_MAX));
        queue_req(KIND_WRAP, VALUE_W'(VAL_MIN));
        queue_req(KIND_SPARE_LO, VALUE_W'(VAL_MAX));      // ignored kinds
        queue_req(KIND_SPARE_HI, VALUE_W'(VAL_MIN));
        queue_req(KIND_PRESET, VALUE_W'(3 * PI_FX));
        queue_req(KIND_ANGLE, VALUE_W'(-PI_FX));          // difference a multiple of 2*pi
        queue_req(KIND_ANGLE, VALUE_W'(TWO_PI_FX + 1));
        queue_req(KIND_UPDATE, '0);
        drain_block();

        for (ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 70;
                recv_idle_pct = 22;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: set_gains(24'd2621, 24'd19661, 16'd655);
                1: set_gains('1, '1, '1);                     // everything saturates
                2: set_gains(24'd6554, 24'd32768, '0);        // position frozen
                3: set_gains(COEF_W'($urandom_range(24'hF_FFFF)),
                             COEF_W'($urandom_range(24'hF_FFFF)), STEP_W'($urandom));
                4: set_gains(24'd1, '0, '1);
                default: set_gains(COEF_W'($urandom), COEF_W'($urandom), STEP_W'($urandom));
            endcase
            @(negedge i_clk);
            fill_random(PHASE_ITEMS);
            drain_block();
        end

        if (mismatch_count == 0 && tracked_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sotd_pkg.sv
rtl/second_order_tracking_differentiator_core.sv
rtl/sotd_chk.sv
bench/second_order_tracking_differentiator_core_tb.sv
